// File: hw/rtl/slsc_pkg.sv
package slsc_pkg;

  localparam int SETS_DEF      = 2048;
  localparam int WAYS_DEF      = 8;
  localparam int ADDR_BITS_DEF = 32;

  localparam int TAG_W = 29;
  localparam int AGE_W = 3;
  localparam logic [AGE_W-1:0] AGE_MAX = 3'd7;

  localparam logic [2:0] OFF_MIN = 3'd3;
  localparam logic [3:0] IDX_MAX = 4'd11;

  localparam logic [1:0] CFG_LINE_SHIFT = 2'd0;
  localparam logic [1:0] CFG_SET_BITS   = 2'd1;
  localparam logic [1:0] CFG_WAYS_LOG2  = 2'd2;

  localparam logic [1:0] ACC_WRITE = 2'd1;
  localparam logic [1:0] ACC_FETCH = 2'd2;

  typedef struct packed {
    logic [TAG_W-1:0] tag;
    logic             valid;
    logic             dirty;
    logic             prot;
    logic [AGE_W-1:0] age;
  } way_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOOK
  } state_t;

endpackage

// File: hw/rtl/slsc_ram.sv
module slsc_ram #(
  parameter int W  = 8,
  parameter int D  = 16,
  parameter int AW = (D > 1) ? $clog2(D) : 1
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [W-1:0]  wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [W-1:0]  rdata
);

  logic [W-1:0] mem [D];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: hw/rtl/segmented_lru_split_cache.sv
// Tag and replacement engine for split instruction/data caches under
// segmented LRU. One item is an access (access_type, address); each item
// gives exactly one result (hit, way, writeback, icache).
// Channels: in_ and out_ use valid/stall, an item moves when valid is high
// and stall low. cfg_ writes a register (0 line offset width, 1 set index
// width, 2 ways_log2) when cfg_valid and cfg_ready are high; cfg_ready is
// always high, and writes belong to idle periods only.
// Each set of one store is a single row of a synchronous RAM holding all
// ways. The accept cycle reads the row; the next cycle updates and writes
// it back and loads the output register. The read-modify-write on that
// single RAM port pair lets a new item in only after the previous one has
// been written back; the result is registered in the output register.
// Reset starts a clearing pass over all 2*SETS rows (4096 at the defaults),
// one row a cycle, during which in_stall is high.
// When the receiver stalls, the result stays in the output register; the
// next item may be accepted meanwhile and waits in its update cycle until
// the output register frees.
module segmented_lru_split_cache
  import slsc_pkg::*;
#(
  parameter int SETS      = SETS_DEF,
  parameter int WAYS      = WAYS_DEF,
  parameter int ADDR_BITS = ADDR_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_access_type,
  input  logic [31:0] in_address,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_hit,
  output logic [2:0]  out_way,
  output logic        out_writeback,
  output logic        out_icache,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [3:0]  cfg_data
);

  localparam int DEPTH = 2 * SETS;
  localparam int RA_W  = $clog2(DEPTH);
  localparam int SET_W = (SETS > 1) ? $clog2(SETS) : 1;
  localparam int WAY_W = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int CNT_W = $clog2(WAYS + 1);
  localparam int ROW_W = WAYS * $bits(way_t);
  localparam logic [32:0] AMASK = (ADDR_BITS >= 32) ? {33{1'b1}}
                                  : ((33'd1 << ADDR_BITS) - 33'd1);
  localparam int RCP_SH = 11 + $clog2(SETS);
  localparam logic [31:0] RCP_MUL =
    32'(((64'd1 << RCP_SH) + 64'(SETS) - 64'd1) / 64'(SETS));

  typedef way_t [WAYS-1:0] row_t;

  state_t state_r, state_nxt;
  logic [RA_W-1:0] clr_r;
  logic [2:0] line_sh_r;
  logic [3:0] set_bits_r;
  logic [1:0] ways_log2_r;
  logic [TAG_W-1:0] tag_r;
  logic [RA_W-1:0] row_r;
  logic ic_r, wr_r;
  logic out_valid_r, out_hit_r, out_wb_r, out_ic_r;
  logic [2:0] out_way_r;

  logic ram_we, ram_re;
  logic [RA_W-1:0] ram_waddr;
  logic [ROW_W-1:0] ram_wdata, ram_rdata;

  logic accept, proceed, clr_done;

  assign accept   = in_valid && !in_stall;
  assign proceed  = !out_valid_r || !out_stall;
  assign clr_done = (clr_r == RA_W'(DEPTH - 1));

  // set index reduction by the set count: reciprocal multiply, then subtract
  function automatic logic [SET_W-1:0] set_mod(input logic [10:0] s);
    logic [31:0] q;
    logic [31:0] r;
    q = (32'(s) * RCP_MUL) >> RCP_SH;
    r = 32'(s) - q * 32'(SETS);
    return r[SET_W-1:0];
  endfunction

  // accept-side address split
  logic [2:0] off_c;
  logic [3:0] ib_c;
  logic [31:0] addr_c, shr_c, tag_full_c;
  logic [10:0] set_raw_c;
  logic [SET_W-1:0] set_c;
  logic ic_c;
  logic [RA_W-1:0] row_c;

  always_comb begin
    off_c      = (line_sh_r < OFF_MIN) ? OFF_MIN : line_sh_r;
    ib_c       = (set_bits_r > IDX_MAX) ? IDX_MAX : set_bits_r;
    addr_c     = in_address & AMASK[31:0];
    shr_c      = addr_c >> off_c;
    set_raw_c  = shr_c[10:0] & 11'((12'd1 << ib_c) - 12'd1);
    tag_full_c = addr_c >> (5'(off_c) + 5'(ib_c));
    set_c      = set_mod(set_raw_c);
    ic_c       = (in_access_type == ACC_FETCH);
    row_c      = ic_c ? RA_W'(SETS) + RA_W'(set_c) : RA_W'(set_c);
  end

  // update of one set row
  row_t rd_row, new_row;
  logic [WAYS-1:0] inuse;
  logic [4:0] n_raw, n_use, cap;
  logic hit_f, emp_f, prb_f, any_f, prt_f;
  logic [WAY_W-1:0] hit_w, emp_w, prb_w, any_w, prt_w, vic_w;
  logic [AGE_W-1:0] old_age;
  logic [CNT_W-1:0] pcnt;
  logic wb_c;
  logic [WAY_W+3:0] way_x;

  assign rd_row = row_t'(ram_rdata);

  always_comb begin
    n_raw = 5'd1 << ways_log2_r;
    n_use = (32'(n_raw) > WAYS) ? 5'(WAYS) : n_raw;
    cap   = (n_use >> 1) == 5'd0 ? 5'd1 : (n_use >> 1);
    for (int v = 0; v < WAYS; v++) begin
      inuse[v] = (5'(v) < n_use);
    end

    hit_f = 1'b0; hit_w = '0;
    emp_f = 1'b0; emp_w = '0;
    prb_f = 1'b0; prb_w = '0;
    any_f = 1'b0; any_w = '0;
    for (int v = WAYS - 1; v >= 0; v--) begin
      if (inuse[v] && rd_row[v].valid && rd_row[v].tag == tag_r) begin
        hit_f = 1'b1; hit_w = WAY_W'(v);
      end
      if (inuse[v] && !rd_row[v].valid) begin
        emp_f = 1'b1; emp_w = WAY_W'(v);
      end
    end
    for (int v = 0; v < WAYS; v++) begin
      if (inuse[v] && rd_row[v].valid && !rd_row[v].prot &&
          (!prb_f || rd_row[v].age > rd_row[prb_w].age)) begin
        prb_f = 1'b1; prb_w = WAY_W'(v);
      end
      if (inuse[v] && rd_row[v].valid &&
          (!any_f || rd_row[v].age > rd_row[any_w].age)) begin
        any_f = 1'b1; any_w = WAY_W'(v);
      end
    end

    if (hit_f)      vic_w = hit_w;
    else if (emp_f) vic_w = emp_w;
    else if (prb_f) vic_w = prb_w;
    else if (any_f) vic_w = any_w;
    else            vic_w = '0;

    old_age = rd_row[vic_w].valid ? rd_row[vic_w].age : AGE_MAX;
    new_row = rd_row;
    for (int v = 0; v < WAYS; v++) begin
      if (inuse[v] && WAY_W'(v) != vic_w && rd_row[v].valid &&
          rd_row[v].age < old_age) begin
        new_row[v].age = rd_row[v].age + 3'd1;
      end
    end
    new_row[vic_w].age = '0;

    pcnt = '0;
    for (int v = 0; v < WAYS; v++) begin
      pcnt = pcnt + CNT_W'(inuse[v] && rd_row[v].valid && rd_row[v].prot);
    end
    // oldest protected line, ranked after the touch
    prt_f = 1'b0; prt_w = '0;
    for (int v = 0; v < WAYS; v++) begin
      if (inuse[v] && new_row[v].valid && new_row[v].prot &&
          (!prt_f || new_row[v].age > new_row[prt_w].age)) begin
        prt_f = 1'b1; prt_w = WAY_W'(v);
      end
    end

    wb_c = 1'b0;
    if (hit_f) begin
      if (wr_r) begin
        new_row[vic_w].dirty = 1'b1;
      end
      if (!rd_row[vic_w].prot) begin
        if (5'(pcnt) >= cap && prt_f) begin
          new_row[prt_w].prot = 1'b0;
        end
        new_row[vic_w].prot = 1'b1;
      end
    end else begin
      wb_c = rd_row[vic_w].valid && rd_row[vic_w].dirty;
      new_row[vic_w].tag   = tag_r;
      new_row[vic_w].valid = 1'b1;
      new_row[vic_w].dirty = wr_r;
      new_row[vic_w].prot  = 1'b0;
    end
    way_x = {4'd0, vic_w};
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR: if (clr_done) state_nxt = ST_IDLE;
      ST_IDLE:  if (in_valid) state_nxt = ST_LOOK;
      ST_LOOK:  if (proceed) state_nxt = ST_IDLE;
      default:  state_nxt = ST_CLEAR;
    endcase
  end

  always_comb begin
    in_stall  = 1'b1;
    ram_we    = 1'b0;
    ram_re    = 1'b0;
    ram_waddr = row_r;
    ram_wdata = ROW_W'(new_row);
    unique case (state_r)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_r;
        ram_wdata = '0;
      end
      ST_IDLE: begin
        in_stall = 1'b0;
        ram_re   = in_valid;
      end
      ST_LOOK: begin
        ram_we = proceed;
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

  slsc_ram #(
    .W (ROW_W),
    .D (DEPTH),
    .AW(RA_W)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(row_c),
    .rdata(ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_r       <= '0;
      line_sh_r   <= 3'd3;
      set_bits_r  <= 4'd7;
      ways_log2_r <= 2'd0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_CLEAR) begin
        clr_r <= clr_r + RA_W'(1);
      end
      if (cfg_valid) begin
        case (cfg_index)
          CFG_LINE_SHIFT: line_sh_r   <= cfg_data[2:0];
          CFG_SET_BITS:   set_bits_r  <= cfg_data;
          CFG_WAYS_LOG2:  ways_log2_r <= cfg_data[1:0];
          default: ;
        endcase
      end
      if (state_r == ST_LOOK && proceed) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      tag_r <= tag_full_c[TAG_W-1:0];
      row_r <= row_c;
      ic_r  <= ic_c;
      wr_r  <= (in_access_type == ACC_WRITE);
    end
    if (state_r == ST_LOOK && proceed) begin
      out_hit_r <= hit_f;
      out_way_r <= way_x[2:0];
      out_wb_r  <= wb_c;
      out_ic_r  <= ic_r;
    end
  end

  assign cfg_ready     = 1'b1;
  assign out_valid     = out_valid_r;
  assign out_hit       = out_hit_r;
  assign out_way       = out_way_r;
  assign out_writeback = out_wb_r;
  assign out_icache    = out_ic_r;

  a_acc_look: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> state_r == ST_LOOK)
    else $error("accepted item did not enter update cycle");

  a_clear_stall: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_CLEAR |-> in_stall && !ram_re)
    else $error("item taken during clearing pass");

  a_rose_out: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(state_r == ST_LOOK))
    else $error("result appeared without an update cycle");

  a_hit_nowb: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_hit |-> !out_writeback)
    else $error("writeback flagged on a hit");

endmodule
